FILE: rtl/core/adfs_pkg.sv
// ----------------------------------------------------------------------------
// adfs_pkg
// Shared constants for the adjacency matrix depth-first search block: field
// widths, opcodes, status codes and the register reset value.
// ----------------------------------------------------------------------------
package adfs_pkg;

   // field widths of the request, response and csr words
   localparam int VERTEX_W = 4;
   localparam int COUNT_W  = 5;

   // vertex_count after reset
   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

   // request opcodes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // response status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

endpackage

FILE: rtl/core/adfs_adj_mem.sv
// ----------------------------------------------------------------------------
// adfs_adj_mem
// Adjacency row memory, one row per vertex, one read and one write port,
// registered read data. Per-row valid bits make every row read as zero
// after reset until it is first written.
// ----------------------------------------------------------------------------
module adfs_adj_mem #(
   parameter int MAX_VERTICES = 16,
   parameter int VW           = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rd_en,
   input  logic [VW-1:0]           rd_addr,
   output logic [MAX_VERTICES-1:0] rd_data,
   input  logic                    wr_en,
   input  logic [VW-1:0]           wr_addr,
   input  logic [MAX_VERTICES-1:0] wr_data
);

   logic [MAX_VERTICES-1:0] rows_ff [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] row_valid_ff;
   logic [MAX_VERTICES-1:0] rd_data_ff;

   // row storage, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rows_ff[wr_addr] <= wr_data;
      end
   end

   // registered read; unwritten rows read as zero
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= row_valid_ff[rd_addr] ? rows_ff[rd_addr] : '0;
      end
   end

   // valid bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/adfs_stack_mem.sv
// ----------------------------------------------------------------------------
// adfs_stack_mem
// Search stack of parent vertices: one read and one write port, registered
// read data. Entries are always pushed before they are popped.
// ----------------------------------------------------------------------------
module adfs_stack_mem #(
   parameter int MAX_VERTICES = 16,
   parameter int VW           = 4
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [VW-1:0] rd_addr,
   output logic [VW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [VW-1:0] wr_addr,
   input  logic [VW-1:0] wr_data
);

   logic [VW-1:0] entries_ff [MAX_VERTICES];
   logic [VW-1:0] rd_data_ff;

   // push
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
   end

   // pop read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entries_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/adjacency_matrix_dfs.sv
// ----------------------------------------------------------------------------
// Insert: two row read-modify-writes (row a in INS_A, row b in INS_B), then the
// word strobes and the next request is taken in that cycle; out of range: strobed
// in the next cycle, no busy. Search: each push is one SCAN step; each backtrack
// reads the stack in SCAN, then the parent's row in POP.
// Words strobe one cycle; receiver cannot stall.
// Synchronous active-high reset clears the matrix (valid bits), marks, state.
// ----------------------------------------------------------------------------
// adjacency_matrix_dfs
// Undirected graph in a bit adjacency matrix with edge insert and
// depth-first search that reports vertices in visit order.
// ----------------------------------------------------------------------------
module adjacency_matrix_dfs #(
   parameter int MAX_VERTICES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_opcode,
   input  logic [adfs_pkg::VERTEX_W-1:0] req_vertex_a,
   input  logic [adfs_pkg::VERTEX_W-1:0] req_vertex_b,
   output logic                          rsp_strobe,
   output logic [adfs_pkg::VERTEX_W-1:0] rsp_vertex,
   output logic                          rsp_last,
   output logic                          rsp_status,
   input  logic                          csr_we,
   input  logic [adfs_pkg::COUNT_W-1:0]  csr_wdata
);

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int LW = (CW > adfs_pkg::COUNT_W) ? CW : adfs_pkg::COUNT_W;
   localparam int MV = MAX_VERTICES;

   // state codes
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_INS_A = 3'd1;
   localparam logic [2:0] ST_INS_B = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_POP   = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [adfs_pkg::COUNT_W-1:0] count_ff;
   logic [MV-1:0]                visited_ff, visited_in;
   logic [VW-1:0]                pend_ff, pend_in;
   logic [VW-1:0]                cur_ff, cur_in;
   logic [VW-1:0]                depth_ff, depth_in;
   logic [VW-1:0]                a_ff, a_in;
   logic [VW-1:0]                b_ff, b_in;
   logic                         rsp_strobe_ff, rsp_strobe_in;
   logic [adfs_pkg::VERTEX_W-1:0] rsp_vertex_ff, rsp_vertex_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic                         rsp_status_ff, rsp_status_in;

   // memory ports
   logic                 adj_rd_en, adj_wr_en;
   logic [VW-1:0]        adj_rd_addr, adj_wr_addr;
   logic [MV-1:0]        adj_rd_data, adj_wr_data;
   logic                 stk_rd_en, stk_wr_en;
   logic [VW-1:0]        stk_rd_addr, stk_wr_addr, stk_wr_data;
   logic [VW-1:0]        stk_rd_data;

   logic [LW-1:0]        live_n;
   logic [LW-1:0]        a_ext, b_ext;
   logic                 a_ok, b_ok;
   logic [MV-1:0]        live_mask;
   logic [MV-1:0]        cand;
   logic                 found;
   logic [VW-1:0]        next_w;

   adfs_adj_mem #(.MAX_VERTICES(MV), .VW(VW)) u_adj (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (adj_rd_en),
      .rd_addr (adj_rd_addr),
      .rd_data (adj_rd_data),
      .wr_en   (adj_wr_en),
      .wr_addr (adj_wr_addr),
      .wr_data (adj_wr_data)
   );

   adfs_stack_mem #(.MAX_VERTICES(MV), .VW(VW)) u_stack (
      .clock   (clock),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data)
   );

   // live vertex count, saturated at the matrix size
   always_comb begin
      if (LW'(count_ff) > LW'(MV)) begin
         live_n = LW'(MV);
      end else begin
         live_n = LW'(count_ff);
      end
   end

   assign a_ext = LW'(req_vertex_a);
   assign b_ext = LW'(req_vertex_b);
   assign a_ok  = a_ext < live_n;
   assign b_ok  = b_ext < live_n;

   // vertices below the live count
   always_comb begin
      for (int i = 0; i < MV; i++) begin
         live_mask[i] = LW'(i) < live_n;
      end
   end

   // unvisited live neighbors of the current vertex, lowest first
   assign cand = adj_rd_data & ~visited_ff & live_mask;

   always_comb begin
      found  = 1'b0;
      next_w = '0;
      for (int i = MV - 1; i >= 0; i--) begin
         if (cand[i]) begin
            found  = 1'b1;
            next_w = VW'(i);
         end
      end
   end

   // control sequencer
   always_comb begin
      state_in      = state_ff;
      visited_in    = visited_ff;
      pend_in       = pend_ff;
      cur_in        = cur_ff;
      depth_in      = depth_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      rsp_strobe_in = 1'b0;
      rsp_vertex_in = '0;
      rsp_last_in   = 1'b1;
      rsp_status_in = adfs_pkg::STATUS_OK;
      adj_rd_en     = 1'b0;
      adj_rd_addr   = '0;
      adj_wr_en     = 1'b0;
      adj_wr_addr   = '0;
      adj_wr_data   = '0;
      stk_rd_en     = 1'b0;
      stk_rd_addr   = '0;
      stk_wr_en     = 1'b0;
      stk_wr_addr   = '0;
      stk_wr_data   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               a_in = a_ext[VW-1:0];
               b_in = b_ext[VW-1:0];
               if (req_opcode == adfs_pkg::OP_INSERT) begin
                  if (a_ok && b_ok) begin
                     adj_rd_en   = 1'b1;
                     adj_rd_addr = a_ext[VW-1:0];
                     state_in    = ST_INS_A;
                  end else begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = adfs_pkg::STATUS_RANGE;
                  end
               end else begin
                  if (a_ok) begin
                     adj_rd_en   = 1'b1;
                     adj_rd_addr = a_ext[VW-1:0];
                     visited_in  = MV'(1) << a_ext[VW-1:0];
                     pend_in     = a_ext[VW-1:0];
                     cur_in      = a_ext[VW-1:0];
                     depth_in    = '0;
                     state_in    = ST_SCAN;
                  end else begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = adfs_pkg::STATUS_RANGE;
                  end
               end
            end
         end

         // row a arrives: set bit b, fetch row b
         ST_INS_A: begin
            adj_wr_en   = 1'b1;
            adj_wr_addr = a_ff;
            adj_wr_data = adj_rd_data | (MV'(1) << b_ff);
            adj_rd_en   = 1'b1;
            adj_rd_addr = b_ff;
            state_in    = ST_INS_B;
         end

         // row b arrives: set bit a, answer
         ST_INS_B: begin
            adj_wr_en     = 1'b1;
            adj_wr_addr   = b_ff;
            adj_wr_data   = adj_rd_data | (MV'(1) << a_ff);
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end

         // row of the current vertex is valid: push or backtrack
         ST_SCAN: begin
            if (found) begin
               rsp_strobe_in = 1'b1;
               rsp_vertex_in = adfs_pkg::VERTEX_W'(pend_ff);
               rsp_last_in   = 1'b0;
               pend_in       = next_w;
               visited_in    = visited_ff | (MV'(1) << next_w);
               stk_wr_en     = 1'b1;
               stk_wr_addr   = depth_ff;
               stk_wr_data   = cur_ff;
               depth_in      = depth_ff + VW'(1);
               cur_in        = next_w;
               adj_rd_en     = 1'b1;
               adj_rd_addr   = next_w;
            end else if (depth_ff == '0) begin
               rsp_strobe_in = 1'b1;
               rsp_vertex_in = adfs_pkg::VERTEX_W'(pend_ff);
               state_in      = ST_IDLE;
            end else begin
               stk_rd_en   = 1'b1;
               stk_rd_addr = depth_ff - VW'(1);
               depth_in    = depth_ff - VW'(1);
               state_in    = ST_POP;
            end
         end

         // parent arrives from the stack: fetch its row
         ST_POP: begin
            cur_in      = stk_rd_data;
            adj_rd_en   = 1'b1;
            adj_rd_addr = stk_rd_data;
            state_in    = ST_SCAN;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= adfs_pkg::COUNT_RESET;
         visited_ff    <= '0;
         depth_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         visited_ff    <= visited_in;
         depth_ff      <= depth_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_ff       <= pend_in;
      cur_ff        <= cur_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_vertex = rsp_vertex_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_status = rsp_status_ff;

endmodule
